// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    word_t   key;
    word_t   value;
  } req_t;

  typedef struct packed {
    logic  hit;
    word_t read_value;
  } rsp_t;

endpackage

// ===== rtl/lkv_req_if.sv =====
interface lkv_req_if;
  logic             valid;
  logic             ready;
  lkv_pkg::action_t action;
  lkv_pkg::word_t   key;
  lkv_pkg::word_t   value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

// ===== rtl/lkv_rsp_if.sv =====
interface lkv_rsp_if;
  logic           valid;
  logic           ready;
  logic           hit;
  lkv_pkg::word_t read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/lru_key_value_cache.sv =====
// Channel  Direction  Payload                      Handshake
// in_if    sink       action, key, value           valid/ready
// out_if   source     hit, read_value              valid/ready
// cfg      write      cfg_wdata -> capacity        cfg_we, no ready
//
// One request per cycle while out_if is not stalled. A request sits in the
// input register; then key compare, slot pick and age update write the entry
// state and the result register together.
// Synchronous reset clears valid bits and live count and sets capacity to 16.
// A stalled result holds the request stage, which still takes a new request
// in the cycle the result is taken.
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lkv_req_if.sink                   in_if,
  lkv_rsp_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic             req_valid, go;
  req_t             req;
  rsp_t             rsp, rsp_r;
  logic             out_valid_r, out_valid_nxt;

  lkv_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .take      (go),
    .req_valid (req_valid),
    .req       (req)
  );

  lkv_store #(.ENTRIES(ENTRIES)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .req   (req),
    .cap   (capacity_r),
    .rsp   (rsp)
  );

  // advance when the result slot is empty or being drained
  assign go = req_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp_r <= rsp;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.hit        = rsp_r.hit;
  assign out_if.read_value = rsp_r.read_value;
endmodule

// ===== rtl/lkv_in_stage.sv =====
module lkv_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  lkv_req_if.sink         in_if,
  input  logic            take,
  output logic            req_valid,
  output lkv_pkg::req_t   req
);
  import lkv_pkg::*;

  logic vld_r, vld_nxt;
  req_t req_r;
  logic accept;

  assign in_if.ready = !vld_r || take;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= '{action: in_if.action, key: in_if.key, value: in_if.value};
    end
  end

  assign req_valid = vld_r;
  assign req       = req_r;
endmodule

// ===== rtl/lkv_store.sv =====
module lkv_store #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  lkv_pkg::req_t             req,
  input  logic [lkv_pkg::CAP_W-1:0] cap,
  output lkv_pkg::rsp_t             rsp
);
  import lkv_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  word_t              key_r  [ENTRIES];
  word_t              data_r [ENTRIES];
  logic [AW-1:0]      age_r  [ENTRIES];
  logic [AW-1:0]      age_nxt[ENTRIES];

  logic [ENTRIES-1:0] hit_vec, free_vec, victim_vec, tgt_vec;
  logic               hit, is_put, alloc, has_room, upd, tgt_was_valid;
  word_t              hit_data;
  logic [AW-1:0]      hit_age, oldest, tgt_old_age;
  logic [MW-1:0]      cap_m, cnt_m, eff_cap;

  always_comb begin
    hit_data = '0;
    hit_age  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == req.key);
      victim_vec[i] = valid_r[i] && (age_r[i] == oldest);
      hit_data      = hit_data | (hit_vec[i] ? data_r[i] : '0);
      hit_age       = hit_age | (hit_vec[i] ? age_r[i] : '0);
    end
  end

  // lowest clear bit of the valid vector
  assign free_vec = (valid_r + ENTRIES'(1)) & ~valid_r;
  // ages form a permutation of 0..count-1, so the oldest has age count-1
  assign oldest   = AW'(count_r - CW'(1));

  assign hit    = |hit_vec;
  assign is_put = (req.action == ACT_PUT);

  always_comb begin
    cap_m = MW'(cap);
    cnt_m = MW'(count_r);
    if (cap_m == '0) begin
      eff_cap = MW'(1);
    end else if (cap_m > MW'(ENTRIES)) begin
      eff_cap = MW'(ENTRIES);
    end else begin
      eff_cap = cap_m;
    end
  end

  assign has_room      = cnt_m < eff_cap;
  assign alloc         = is_put && !hit && has_room;
  assign upd           = hit || is_put;
  assign tgt_vec       = hit ? hit_vec : (alloc ? free_vec : victim_vec);
  assign tgt_was_valid = hit || !alloc;
  assign tgt_old_age   = hit ? hit_age : oldest;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt_vec[i]) begin
        age_nxt[i] = '0;
      end else if (valid_r[i] && (!tgt_was_valid || age_r[i] < tgt_old_age)) begin
        age_nxt[i] = age_r[i] + AW'(1);
      end else begin
        age_nxt[i] = age_r[i];
      end
    end
    valid_nxt = valid_r | tgt_vec;
    count_nxt = count_r + CW'(alloc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (go && upd) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
        if (tgt_vec[i] && is_put) begin
          data_r[i] <= req.value;
          if (!hit) begin
            key_r[i] <= req.key;
          end
        end
      end
    end
  end

  assign rsp.hit        = hit;
  assign rsp.read_value = (!is_put && hit) ? hit_data : '0;
endmodule
